FILE: sv/fsp_pkg.sv
// Shared constants and control/status types for the particle sensor frame parser.
`default_nettype none

package fsp_pkg;

    // Frame header bytes
    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;

    // Result status codes
    localparam logic [1:0] STAT_DATA    = 2'd0;
    localparam logic [1:0] STAT_CSUM    = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    // Timeout register value after reset, in ticks
    localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

    // Commands from controller to datapath
    typedef struct packed {
        logic       tick;         // saturating increment of the tick counter
        logic       clr_frame;    // back to hunting: count, sum, ticks cleared
        logic       hdr1;         // first header byte seen
        logic       hdr2;         // second header byte seen
        logic       drop;         // false start, drop partial header
        logic       body;         // store one body byte
        logic       ld_err;       // load an error result
        logic [1:0] err_code;     // status of that error result
        logic       start_words;  // begin emitting data words at word 0
        logic       next_word;    // advance to the next data word
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic hdr1;         // current byte is the first header byte
        logic hdr2;         // current byte is the second header byte
        logic frame_done;   // current byte completes the frame
        logic sum_ok;       // running sum matches the checksum word
        logic timeout_hit;  // a tick now would reach the timeout
        logic out_last;     // pending result is the final one of its run
    } t_dp_status;

endpackage

`default_nettype wire

FILE: sv/fsp_datapath.sv
// Datapath: frame store, running sum, tick counter, timeout register and result fields.
`default_nettype none

module fsp_datapath #(
    parameter int FRAME_BYTES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire fsp_pkg::t_cmd      i_cmd,
    output fsp_pkg::t_dp_status     o_status,
    output logic [1:0]              o_res_status,
    output logic [3:0]              o_word_index,
    output logic [15:0]             o_value,
    output logic                    o_last
);
    import fsp_pkg::*;

    localparam int NWORDS = (FRAME_BYTES - 4) / 2;
    localparam int AW     = $clog2(FRAME_BYTES);
    localparam int KW     = $clog2(NWORDS);

    logic [AW-1:0]  r_count,   n_count;
    logic [15:0]    r_sum,     n_sum;
    logic [15:0]    r_elapsed, n_elapsed;
    logic [15:0]    r_timeout;
    logic [KW-1:0]  r_k;
    logic [1:0]     r_out_status;
    logic [7:0]     r_prev;
    logic [7:0]     r_store [FRAME_BYTES];
    logic [7:0]     r_rd_hi, r_rd_lo;

    logic [15:0]    elapsed_inc;
    logic [AW-1:0]  addr_hi, addr_lo;
    logic           sum_add;

    // Saturating tick count and word read addresses
    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign addr_hi     = AW'({r_k, 1'b0}) + AW'(2);
    assign addr_lo     = AW'({r_k, 1'b0}) + AW'(3);
    assign sum_add     = (r_count < AW'(FRAME_BYTES - 2));

    // Next frame tracking state; clearing the frame wins over everything
    always_comb begin
        n_count   = r_count;
        n_sum     = r_sum;
        n_elapsed = r_elapsed;
        if (i_cmd.tick) begin
            n_elapsed = elapsed_inc;
        end
        if (i_cmd.hdr1) begin
            n_sum   = {8'h00, i_byte};
            n_count = AW'(1);
        end
        if (i_cmd.hdr2) begin
            n_sum     = r_sum + {8'h00, i_byte};
            n_count   = AW'(2);
            n_elapsed = '0;
        end
        if (i_cmd.drop) begin
            n_sum   = '0;
            n_count = '0;
        end
        if (i_cmd.body) begin
            if (sum_add) begin
                n_sum = r_sum + {8'h00, i_byte};
            end
            n_count = r_count + AW'(1);
        end
        if (i_cmd.clr_frame) begin
            n_sum     = '0;
            n_count   = '0;
            n_elapsed = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum        <= '0;
            r_elapsed    <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_k          <= '0;
            r_out_status <= STAT_DATA;
        end else begin
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_elapsed <= n_elapsed;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.start_words) begin
                r_k <= '0;
            end else if (i_cmd.next_word) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.ld_err) begin
                r_out_status <= i_cmd.err_code;
            end else if (i_cmd.start_words) begin
                r_out_status <= STAT_DATA;
            end
        end
    end

    // Frame store: one byte written per body beat, two bytes read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.body) begin
            r_store[r_count] <= i_byte;
            r_prev           <= i_byte;
        end
        r_rd_hi <= r_store[addr_hi];
        r_rd_lo <= r_store[addr_lo];
    end

    // Status to the controller
    assign o_status.hdr1        = (i_byte == HDR_FIRST);
    assign o_status.hdr2        = (i_byte == HDR_SECOND);
    assign o_status.frame_done  = (r_count == AW'(FRAME_BYTES - 1));
    assign o_status.sum_ok      = (r_sum == {r_prev, i_byte});
    assign o_status.timeout_hit = (elapsed_inc >= r_timeout);
    assign o_status.out_last    = (r_out_status != STAT_DATA) || (r_k == KW'(NWORDS - 1));

    // Result fields; error results carry zero index and value
    assign o_res_status = r_out_status;
    assign o_word_index = (r_out_status == STAT_DATA) ? 4'(r_k) : 4'd0;
    assign o_value      = (r_out_status == STAT_DATA) ? {r_rd_hi, r_rd_lo} : 16'd0;
    assign o_last       = o_status.out_last;

endmodule

`default_nettype wire

FILE: sv/fsp_ctrl.sv
// Controller: header hunt, body collection and result sequencing state machine.
`default_nettype none

module fsp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_mode,
    input  wire logic                i_out_ready,
    input  wire fsp_pkg::t_dp_status i_status,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output fsp_pkg::t_cmd            o_cmd
);
    import fsp_pkg::*;

    typedef enum logic [4:0] {
        ST_HUNT   = 5'b00001,
        ST_SECOND = 5'b00010,
        ST_BODY   = 5'b00100,
        ST_READ   = 5'b01000,
        ST_OUT    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   tick_fire, byte_fire, out_fire;

    assign o_in_ready  = (r_state == ST_HUNT) || (r_state == ST_SECOND) ||
                         (r_state == ST_BODY);
    assign o_out_valid = (r_state == ST_OUT);
    assign tick_fire   = i_in_valid && o_in_ready && i_in_mode;
    assign byte_fire   = i_in_valid && o_in_ready && !i_in_mode;
    assign out_fire    = o_out_valid && i_out_ready;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.err_code = STAT_DATA;

        // Ticks count in every parsing phase
        if (tick_fire) begin
            o_cmd.tick = 1'b1;
            if (i_status.timeout_hit) begin
                o_cmd.clr_frame = 1'b1;
                o_cmd.ld_err    = 1'b1;
                o_cmd.err_code  = STAT_TIMEOUT;
                n_state         = ST_OUT;
            end
        end

        case (r_state)
            ST_HUNT: begin
                if (byte_fire && i_status.hdr1) begin
                    o_cmd.hdr1 = 1'b1;
                    n_state    = ST_SECOND;
                end
            end
            ST_SECOND: begin
                if (byte_fire) begin
                    if (i_status.hdr2) begin
                        o_cmd.hdr2 = 1'b1;
                        n_state    = ST_BODY;
                    end else begin
                        o_cmd.drop = 1'b1;
                        n_state    = ST_HUNT;
                    end
                end
            end
            ST_BODY: begin
                if (byte_fire) begin
                    o_cmd.body = 1'b1;
                    if (i_status.frame_done) begin
                        o_cmd.clr_frame = 1'b1;
                        if (i_status.sum_ok) begin
                            o_cmd.start_words = 1'b1;
                            n_state           = ST_READ;
                        end else begin
                            o_cmd.ld_err   = 1'b1;
                            o_cmd.err_code = STAT_CSUM;
                            n_state        = ST_OUT;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        n_state = ST_HUNT;
                    end else begin
                        o_cmd.next_word = 1'b1;
                        n_state         = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Input and output sides never both open
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    // A word read always lands in the output stage next
    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_OUT))
        else $error("memory read not followed by output");

    // Final result of a run returns to hunting
    a_last_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && i_status.out_last) |=> (r_state == ST_HUNT))
        else $error("run did not end after last beat");

    // A tick that reaches the timeout always yields a result
    a_timeout_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_fire && i_status.timeout_hit) |=> (r_state == ST_OUT))
        else $error("timeout without result");

endmodule

`default_nettype wire

FILE: sv/particle_sensor_frame_parser.sv
// Top level of the particle sensor frame parser: stream ports, controller and datapath.
//
// Input stream: one beat per received serial byte (tuser = 0, byte in tdata) or
// per one-millisecond tick (tuser = 1, tdata ignored). The parser hunts for the
// 0x42 0x4D header, stores the rest of the frame and checks its 16-bit sum.
// Output stream: one beat per result. tuser holds the status (data word,
// checksum error, timeout); tdata holds word index and the big-endian word.
// tlast marks the final beat of a run; every error result is a single beat.
// A checksum error or timeout result is valid the cycle after the beat that
// caused it. A good frame yields FRAME_BYTES/2-2 words, each passing through
// a frame store read state and then an output state. s_axis_tready is low
// while results are pending. A stalled output beat holds its data until taken.
// The timeout register is written through i_cfg_we/i_cfg_wdata; the user must
// write it only while the parser is idle, which the block does not enforce.
// Reset puts the parser in the hunt with the timeout set to 1500 ticks.
`default_nettype none

module particle_sensor_frame_parser #(
    parameter int FRAME_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [3:0] word_index, [19:4] value, [23:20] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);
    import fsp_pkg::*;

    t_cmd        cmd;
    t_dp_status  dp_status;
    logic [3:0]  word_index;
    logic [15:0] value;

    fsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser[0]),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    fsp_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (s_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_status     (dp_status),
        .o_res_status (m_axis_tuser),
        .o_word_index (word_index),
        .o_value      (value),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, value, word_index};

endmodule

`default_nettype wire

FILE: tb/sv/particle_sensor_frame_parser_tb.sv
// Self-checking testbench for the particle sensor frame parser: directed table, then random frames.
module particle_sensor_frame_parser_tb;
    import fsp_pkg::*;

    localparam int FRAME_BYTES  = 32;
    localparam int NUM_WORDS    = (FRAME_BYTES - 4) / 2;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_BEATS  = 25;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, IN_BODY} hunt_phase_t;
    typedef enum logic {ROW_BEAT, ROW_SET_TIMEOUT} row_kind_t;
    typedef enum logic [1:0] {ALWAYS_READY, MASKED, COIN_FLIP} stall_style_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  word_index;
        logic [15:0] value;
        logic        last;
    } frame_result_t;

    typedef struct packed {
        row_kind_t     kind;
        logic          mode;
        logic [15:0]   data;    // byte in [7:0] for beats, register value for writes
        logic          typed;   // want holds the result this beat must produce
        frame_result_t want;
    } vector_t;

    localparam frame_result_t NONE      = '0;
    localparam frame_result_t TIMED_OUT = '{STAT_TIMEOUT, 4'd0, 16'd0, 1'b1};

    localparam int NUM_DIRECTED = 25;
    localparam vector_t DIRECTED [NUM_DIRECTED] = '{
        // reset timeout: a tick and noise while hunting
        '{ROW_BEAT,        MODE_TICK, 16'h00FF, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h0000, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h00FF, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h004D, 1'b0, NONE},
        // false start: the repeated 0x42 must not open a new header
        '{ROW_BEAT,        MODE_BYTE, 16'h0042, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h0042, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h004D, 1'b0, NONE},
        // real header and two body bytes
        '{ROW_BEAT,        MODE_BYTE, 16'h0042, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h004D, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h00FF, 1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h0000, 1'b0, NONE},
        // short timeout drops the partial frame, count restarted at the second header byte
        '{ROW_SET_TIMEOUT, MODE_BYTE, 16'd2,    1'b0, NONE},
        '{ROW_BEAT,        MODE_TICK, 16'h0000, 1'b0, NONE},
        '{ROW_BEAT,        MODE_TICK, 16'h00A5, 1'b1, TIMED_OUT},
        '{ROW_BEAT,        MODE_BYTE, 16'h004D, 1'b0, NONE},
        // zero timeout: every tick times out
        '{ROW_SET_TIMEOUT, MODE_BYTE, 16'd0,    1'b0, NONE},
        '{ROW_BEAT,        MODE_TICK, 16'h0042, 1'b1, TIMED_OUT},
        '{ROW_BEAT,        MODE_TICK, 16'h00FF, 1'b1, TIMED_OUT},
        // timeout of one while half a header is held
        '{ROW_SET_TIMEOUT, MODE_BYTE, 16'd1,    1'b0, NONE},
        '{ROW_BEAT,        MODE_BYTE, 16'h0042, 1'b0, NONE},
        '{ROW_BEAT,        MODE_TICK, 16'h0000, 1'b1, TIMED_OUT},
        '{ROW_BEAT,        MODE_BYTE, 16'h004D, 1'b0, NONE},
        // largest timeout
        '{ROW_SET_TIMEOUT, MODE_BYTE, 16'hFFFF, 1'b0, NONE},
        '{ROW_BEAT,        MODE_TICK, 16'h005A, 1'b0, NONE},
        '{ROW_BEAT,        MODE_TICK, 16'h0000, 1'b0, NONE}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser  = '0;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [3:0] word_index, [19:4] value, [23:20] zero
    logic [1:0]  m_axis_tuser;         // [1:0] status
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;

    particle_sensor_frame_parser #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Parser image kept by the bench
    logic [15:0]   timeout_reg;
    hunt_phase_t   hunt_phase;
    int unsigned   frame_len;
    logic [15:0]   frame_sum;
    logic [15:0]   tick_count;
    logic [7:0]    frame_bytes [FRAME_BYTES];
    frame_result_t due_results [$];

    int unsigned errors        = 0;
    int unsigned hold_requests = 0;
    int unsigned burst_left    = 0;
    int unsigned live_beats    = 0;
    logic        offering      = 1'b0;

    function automatic void back_to_hunt();
        hunt_phase = HUNT_FIRST;
        frame_len  = 0;
        frame_sum  = '0;
        tick_count = '0;
    endfunction

    // Advance the parser image by one accepted beat, queueing the results it owes
    function automatic void parse_beat(input logic mode, input logic [7:0] b);
        logic [15:0] check;
        int unsigned k;
        if (mode == MODE_TICK) begin
            if (tick_count != 16'hFFFF)
                tick_count++;
            if (tick_count >= timeout_reg) begin
                back_to_hunt();
                due_results.push_back(TIMED_OUT);
            end
        end else if (hunt_phase == HUNT_FIRST) begin
            if (b == HDR_FIRST) begin
                frame_bytes[0] = b;
                frame_sum      = {8'h00, b};
                frame_len      = 1;
                hunt_phase     = HUNT_SECOND;
            end
        end else if (hunt_phase == HUNT_SECOND) begin
            if (b == HDR_SECOND) begin
                frame_bytes[1] = b;
                frame_sum      = frame_sum + {8'h00, b};
                frame_len      = 2;
                tick_count     = '0;
                hunt_phase     = IN_BODY;
            end else begin
                hunt_phase = HUNT_FIRST;
                frame_len  = 0;
                frame_sum  = '0;
            end
        end else if (frame_len >= FRAME_BYTES) begin
            back_to_hunt();
        end else begin
            frame_bytes[frame_len] = b;
            if (frame_len < FRAME_BYTES - 2)
                frame_sum = frame_sum + {8'h00, b};
            frame_len++;
            if (frame_len == FRAME_BYTES) begin
                check = {frame_bytes[FRAME_BYTES-2], frame_bytes[FRAME_BYTES-1]};
                if (frame_sum != check) begin
                    due_results.push_back('{STAT_CSUM, 4'd0, 16'd0, 1'b1});
                end else begin
                    for (k = 0; k < NUM_WORDS; k++)
                        due_results.push_back('{STAT_DATA, 4'(k),
                            {frame_bytes[2+2*k], frame_bytes[3+2*k]}, k == NUM_WORDS - 1});
                end
                back_to_hunt();
            end
        end
    endfunction

    task automatic stop_offering();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        burst_left = 0;
    endtask

    // Offer one beat in the current burst; a typed row replaces what the image owes
    task automatic send_beat(input logic mode, input logic [7:0] b,
                             input logic typed = 1'b0, input frame_result_t want = '0);
        int unsigned owed;
        if (burst_left == 0) begin
            stop_offering();
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= mode;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (!(mode == MODE_BYTE && hunt_phase == HUNT_FIRST && b != HDR_FIRST))
            live_beats++;
        owed = due_results.size();
        parse_beat(mode, b);
        if (typed) begin
            while (due_results.size() > owed)
                void'(due_results.pop_back());
            due_results.push_back(want);
        end
    endtask

    // Register write once the parser has drained
    task automatic set_timeout(input logic [15:0] v);
        stop_offering();
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_reg = v;
    endtask

    // One complete frame, checksum right or wrong, with the odd tick mixed in
    task automatic send_frame(input logic good);
        logic [7:0]  body [FRAME_BYTES];
        logic [15:0] sum;
        int unsigned fill;
        int unsigned i;
        fill    = $urandom_range(0, 9);
        body[0] = HDR_FIRST;
        body[1] = HDR_SECOND;
        sum     = {8'h00, HDR_FIRST} + {8'h00, HDR_SECOND};
        for (i = 2; i < FRAME_BYTES - 2; i++) begin
            if (fill == 0)
                body[i] = 8'h00;
            else if (fill == 1)
                body[i] = 8'hFF;
            else if (fill == 2)
                body[i] = i[0] ? HDR_SECOND : HDR_FIRST;   // header look-alikes in the body
            else
                body[i] = 8'($urandom);
            sum = sum + {8'h00, body[i]};
        end
        if (!good)
            sum = sum ^ 16'($urandom_range(1, 65535));
        body[FRAME_BYTES-2] = sum[15:8];
        body[FRAME_BYTES-1] = sum[7:0];
        for (i = 0; i < FRAME_BYTES; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(MODE_TICK, 8'($urandom));
            send_beat(MODE_BYTE, body[i]);
        end
    endtask

    task automatic random_sequence();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_frame(1'b1);
        end else if (pick < 70) begin
            send_frame(1'b0);
        end else if (pick < 80) begin
            // false start, sometimes with a second 0x42
            b = 8'($urandom);
            if (b == HDR_SECOND || $urandom_range(0, 2) == 0)
                b = HDR_FIRST;
            send_beat(MODE_BYTE, HDR_FIRST);
            send_beat(MODE_BYTE, b);
        end else if (pick < 88 && timeout_reg <= 64) begin
            // truncated frame, then ticks until it is dropped
            send_beat(MODE_BYTE, HDR_FIRST);
            send_beat(MODE_BYTE, HDR_SECOND);
            repeat ($urandom_range(0, FRAME_BYTES - 3)) send_beat(MODE_BYTE, 8'($urandom));
            while (hunt_phase != HUNT_FIRST) send_beat(MODE_TICK, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Output side: compare each accepted beat with the oldest owed result
    always @(posedge i_clk) begin : result_check
        frame_result_t got;
        frame_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tlast};
            if (due_results.size() == 0) begin
                $display({"%0t: unexpected result: expected none, ",
                          "got status %0d index %0d value %h last %b"},
                         $time, got.status, got.word_index, got.value, got.last);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("word_index", 16'(want.word_index), 16'(got.word_index));
                check_field("value", want.value, got.value);
                check_field("last", 16'(want.last), 16'(got.last));
            end
        end
    end

    // Receiver: stall patterns in spans, long hold-off on request
    initial begin : receiver
        int unsigned  holds_done;
        int unsigned  span;
        stall_style_t style;
        logic [7:0]   pattern;
        holds_done = 0;
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                style   = stall_style_t'($urandom_range(0, 2));
                pattern = 8'($urandom);
                for (span = 0; span < 16; span++) begin
                    case (style)
                        ALWAYS_READY: m_axis_tready <= 1'b1;
                        MASKED:       m_axis_tready <= pattern[span % 8];
                        default:      m_axis_tready <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("particle_sensor_frame_parser_tb: FAIL");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        logic [15:0] phase_timeout [3];
        int unsigned p;
        int unsigned i;
        int unsigned start;
        phase_timeout[0] = TIMEOUT_RESET;
        phase_timeout[1] = 16'd40;
        phase_timeout[2] = 16'd5;
        timeout_reg = TIMEOUT_RESET;
        back_to_hunt();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_SET_TIMEOUT)
                set_timeout(DIRECTED[i].data);
            else
                send_beat(DIRECTED[i].mode, DIRECTED[i].data[7:0],
                          DIRECTED[i].typed, DIRECTED[i].want);
        end

        // random phases over several timeouts
        for (p = 0; p < 3; p++) begin
            set_timeout(phase_timeout[p]);
            if (p == 0) begin
                // receiver holds off while frames keep coming, then the sender drains
                hold_requests++;
                send_frame(1'b1);
                send_frame(1'b1);
                stop_offering();
                while (due_results.size() != 0) @(posedge i_clk);
            end
            start = live_beats;
            while (live_beats - start < PHASE_BEATS)
                random_sequence();
        end

        stop_offering();
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("particle_sensor_frame_parser_tb: PASS");
        else
            $display("particle_sensor_frame_parser_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/fsp_pkg.sv
sv/fsp_datapath.sv
sv/fsp_ctrl.sv
sv/particle_sensor_frame_parser.sv
tb/sv/particle_sensor_frame_parser_tb.sv
